### rtl/ulf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_pkg: shared types and constants of the UART line framer
// Payload structs, controller/datapath command and status bundles, and the
// sizing constants of the line store.
// ----------------------------------------------------------------------------
package ulf_pkg;

  localparam int unsigned LINE_DEPTH = 64;
  localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned LEN_W      = $clog2(LINE_DEPTH + 1);

  localparam logic [7:0]  CH_CR            = 8'h0D;
  localparam logic [7:0]  CH_LF            = 8'h0A;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd40;
  localparam logic [15:0] IDLE_MAX         = 16'hFFFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CAUSE_LF   = 1'b0;
  localparam logic CAUSE_IDLE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } ulf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_line;
    logic       empty_line;
    logic       flush_cause;
  } ulf_out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // input transfer completes this cycle
    logic flush_start;  // accepted item closes the line
    logic emit;         // load one result into the output register
  } ulf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic flush_req;    // current input item would flush the line
    logic out_free;     // output register can take a result this cycle
    logic last;         // the next emitted result closes the line
  } ulf_sts_t;

endpackage

### rtl/uart_line_framer_idle_flush.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_framer_idle_flush: UART line assembler with idle timeout
// Gathers received bytes into lines and flushes a line on line feed or
// after a programmable number of idle ticks.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o | in_data_i  (op, data_byte)
//  out     | out_valid_o/out_ready_i | out_data_o (out_byte, last, empty,
//          |                         |             flush_cause)
//  cfg     | cfg_we_i (no wait)      | cfg_data_i (idle_limit)
//
// A byte or tick item that does not flush leaves the input ready for the next.
// A flush holds the input off and emits one result per cycle from the line
// store while the output register is free: one per stored byte, or a single
// result for an empty line.
// The output register lets the next item enter while the last result waits.
// Reset clears line state, idle count and output valid; idle_limit returns
// to 40. The store needs no clearing.
// ----------------------------------------------------------------------------
module uart_line_framer_idle_flush (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ulf_pkg::ulf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ulf_pkg::ulf_out_t out_data_o
);
  import ulf_pkg::*;

  ulf_cmd_t cmd;
  ulf_sts_t sts;

  // Sequence item transfers and flush emission
  ulf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the line, counters and the output register
  ulf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/ulf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_ctrl: framer controller
// Accepts items while idle and walks a flush one result per free output slot.
// ----------------------------------------------------------------------------
module ulf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ulf_pkg::ulf_sts_t sts_i,
  output ulf_pkg::ulf_cmd_t cmd_o
);
  import ulf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.accept      = in_ready_o && in_valid_i;
    cmd_o.flush_start = cmd_o.accept && sts_i.flush_req;
    cmd_o.emit        = (state_q == ST_FLUSH) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.flush_start) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (cmd_o.emit && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_flush_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush_start |=> state_q == ST_FLUSH)
    else $error("flush start did not enter flush state");

  a_emit_only_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !cmd_o.accept)
    else $error("emission overlapped an input transfer");

  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && sts_i.last |=> state_q == ST_IDLE)
    else $error("flush did not end after last result");
`endif

endmodule

### rtl/ulf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_dpath: framer datapath
// Line store, length and idle counters, idle limit register, output register.
// ----------------------------------------------------------------------------
module ulf_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  input  ulf_pkg::ulf_in_t  in_data_i,
  input  ulf_pkg::ulf_cmd_t cmd_i,
  output ulf_pkg::ulf_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ulf_pkg::ulf_out_t out_data_o
);
  import ulf_pkg::*;

  logic [7:0]       mem_q [LINE_DEPTH];
  logic [7:0]       rd_data_q;
  logic [LEN_W-1:0] len_q, len_d, eff_len;
  logic [LEN_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             open_q, open_d;
  logic [15:0]      idle_q, idle_d, idle_inc;
  logic [15:0]      limit_q;
  logic             cause_q;
  logic             out_valid_q, out_valid_d;
  ulf_out_t         out_q;
  logic             is_byte, is_cr, is_lf, do_store, line_empty;

  always_comb begin
    is_byte    = (in_data_i.op == OP_BYTE);
    is_cr      = is_byte && (in_data_i.data_byte == CH_CR);
    is_lf      = is_byte && (in_data_i.data_byte == CH_LF);
    eff_len    = open_q ? len_q : '0;
    do_store   = cmd_i.accept && is_byte && !is_cr && !is_lf
                 && (eff_len < LEN_W'(LINE_DEPTH));
    idle_inc   = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
    line_empty = (len_q == '0);

    sts_o.flush_req = is_lf || (!is_byte && open_q && (idle_inc >= limit_q));
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.last      = line_empty || ((rd_ptr_q + LEN_W'(1)) == len_q);
  end

  // Line state and counters
  always_comb begin
    len_d    = len_q;
    open_d   = open_q;
    idle_d   = idle_q;
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.accept) begin
      if (is_byte) begin
        idle_d = '0;
        open_d = 1'b1;
        len_d  = do_store ? eff_len + LEN_W'(1) : eff_len;
      end else begin
        idle_d = idle_inc;
      end
    end
    if (cmd_i.emit) begin
      if (sts_o.last) begin
        rd_ptr_d = '0;
        len_d    = '0;
        open_d   = 1'b0;
      end else begin
        rd_ptr_d = rd_ptr_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      open_q      <= 1'b0;
      idle_q      <= '0;
      rd_ptr_q    <= '0;
      limit_q     <= IDLE_LIMIT_RESET;
      cause_q     <= CAUSE_LF;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      open_q      <= open_d;
      idle_q      <= idle_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.flush_start) begin
        cause_q <= is_byte ? CAUSE_LF : CAUSE_IDLE;
      end
    end
  end

  // Line store: one write port, one registered read port following rd_ptr
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      mem_q[eff_len[ADDR_W-1:0]] <= in_data_i.data_byte;
    end
    rd_data_q <= mem_q[rd_ptr_d[ADDR_W-1:0]];
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_byte     <= line_empty ? 8'h00 : rd_data_q;
      out_q.last_of_line <= sts_o.last;
      out_q.empty_line   <= line_empty;
      out_q.flush_cause  <= cause_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_DEPTH))
    else $error("line length beyond store depth");

  a_flush_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush_start |=> rd_ptr_q == '0 && open_q)
    else $error("flush started with stale read pointer or closed line");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !sts_o.last |=> rd_ptr_q == $past(rd_ptr_q) + LEN_W'(1))
    else $error("read pointer did not advance");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && sts_o.last |=> !open_q && len_q == '0)
    else $error("line not closed after last result");
`endif

endmodule
